### rtl/core/rmt_pkg.sv
`default_nettype none

package rmt_pkg;

  // Store geometry and field widths
  localparam int unsigned DATA_W   = 17;
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              restart;
  } in_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] median;
    logic [CNT_W-1:0]  stored_count;
    logic              dropped;
  } out_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

### rtl/core/running_median_tracker.sv
// Flow: insert into the sorted chain, SEL registers the middle entries, OUT
//   writes their halved sum to the output register; no new request is taken
//   until OUT is done, and OUT waits while out_stall holds a finished result.
// Reset: synchronous active-low rst_n empties the store (count zero) and
//   clears the FSM and output valid; stored values stay unwritten.
`default_nettype none

module running_median_tracker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rmt_pkg::in_req_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rmt_pkg::out_req_t      out_req
);

  localparam int unsigned DW  = rmt_pkg::DATA_W;
  localparam int unsigned CAP = rmt_pkg::CAPACITY;
  localparam int unsigned CW  = rmt_pkg::CNT_W;

  rmt_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              dropped_r, dropped_nxt;
  logic              out_valid_r, out_valid_nxt;
  rmt_pkg::out_req_t out_req_r, out_req_nxt;

  logic              in_acc;
  logic [CW-1:0]     count_eff;
  logic              full;
  logic              insert_en;
  logic              sel_load;
  logic [DW-1:0]     median;

  logic [DW-1:0]     cell_val [CAP];
  logic              cell_gt  [CAP];

  assign in_acc    = in_valid && !in_stall;
  // a restart empties the store before the new sample goes in
  assign count_eff = in_req.restart ? '0 : count_r;
  assign full      = (count_eff == CW'(CAP));
  assign insert_en = in_acc && !full;

  // ---------------------------------------------------------------------
  // Sorted chain: slot i shifts up whenever its entry is larger than the
  // sample; the first such slot (or the first empty one) takes the sample.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic          occupied;
    logic          at_end;
    logic          prev_gt;
    logic [DW-1:0] prev_val;

    assign occupied = (CW'(i) < count_eff);
    assign at_end   = (CW'(i) == count_eff);

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
    end else begin : g_rest
      assign prev_gt  = cell_gt[i-1];
      assign prev_val = cell_val[i-1];
    end

    rmt_cell u_cell (
      .clk       (clk),
      .insert_en (insert_en),
      .occupied  (occupied),
      .at_end    (at_end),
      .sample    (in_req.sample),
      .prev_gt   (prev_gt),
      .prev_val  (prev_val),
      .gt        (cell_gt[i]),
      .val       (cell_val[i])
    );
  end

  // middle-entry select and halving
  rmt_median u_median (
    .clk      (clk),
    .load     (sel_load),
    .count    (count_r),
    .cell_val (cell_val),
    .median   (median)
  );

  // ---------------------------------------------------------------------
  // Control: IDLE takes a request and inserts, SEL registers the middle
  // entries, OUT writes the result once the output register is free.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    out_req_nxt   = out_req_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    sel_load      = 1'b0;
    case (state_r)
      rmt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dropped_nxt = full;
          count_nxt   = full ? count_eff : (count_eff + CW'(1));
          state_nxt   = rmt_pkg::ST_SEL;
        end
      end
      rmt_pkg::ST_SEL: begin
        sel_load  = 1'b1;
        state_nxt = rmt_pkg::ST_OUT;
      end
      rmt_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_req_nxt.median       = median;
          out_req_nxt.stored_count = count_r;
          out_req_nxt.dropped      = dropped_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = rmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmt_pkg::ST_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_req_r <= out_req_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("store count above capacity");

  a_accept_to_sel: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == rmt_pkg::ST_SEL))
    else $error("accepted request did not move to select");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rmt_pkg::ST_IDLE) |-> in_stall)
    else $error("input not stalled while busy");

  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_req_r.stored_count != '0))
    else $error("result shows empty store");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_req_r.dropped) |-> (out_req_r.stored_count == CW'(CAP)))
    else $error("drop flagged with store not full");

endmodule

`default_nettype wire

### rtl/core/rmt_cell.sv
`default_nettype none

// One slot of the sorted chain. Takes the new sample or its lower neighbor's
// value when the insertion point is at or below this slot.
module rmt_cell (
  input  wire logic                       clk,
  input  wire logic                       insert_en,
  input  wire logic                       occupied,
  input  wire logic                       at_end,
  input  wire logic [rmt_pkg::DATA_W-1:0] sample,
  input  wire logic                       prev_gt,
  input  wire logic [rmt_pkg::DATA_W-1:0] prev_val,
  output logic                            gt,
  output logic [rmt_pkg::DATA_W-1:0]      val
);

  logic [rmt_pkg::DATA_W-1:0] val_r;
  logic [rmt_pkg::DATA_W-1:0] val_nxt;

  // strictly greater: equal samples land after stored ones
  assign gt  = occupied && (val_r > sample);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (insert_en && (gt || at_end)) begin
      val_nxt = prev_gt ? prev_val : sample;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/rmt_median.sv
`default_nettype none

// Picks the two middle entries into registers, then adds and halves them.
module rmt_median (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic [rmt_pkg::CNT_W-1:0]  count,
  input  wire logic [rmt_pkg::DATA_W-1:0] cell_val [rmt_pkg::CAPACITY],
  output logic [rmt_pkg::DATA_W-1:0]      median
);

  logic [rmt_pkg::IDX_W-1:0]  mid_hi;
  logic [rmt_pkg::IDX_W-1:0]  mid_lo;
  logic [rmt_pkg::DATA_W-1:0] lo_r;
  logic [rmt_pkg::DATA_W-1:0] hi_r;
  logic [rmt_pkg::DATA_W:0]   sum;

  // count >= 1 here, so mid_hi >= 1 on even counts
  assign mid_hi = rmt_pkg::IDX_W'(count >> 1);
  assign mid_lo = count[0] ? mid_hi : (mid_hi - rmt_pkg::IDX_W'(1));

  always_ff @(posedge clk) begin
    if (load) begin
      lo_r <= cell_val[mid_lo];
      hi_r <= cell_val[mid_hi];
    end
  end

  assign sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign median = sum[rmt_pkg::DATA_W:1];

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SAMPLE_MAX    = (1 << rmt_pkg::DATA_W) - 1;
  localparam int unsigned PHASE_ITEMS   = 230;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned NUM_DIRECTED  = 20;

  // Value shapes for the random sequences
  localparam int unsigned VAL_FULL    = 0;
  localparam int unsigned VAL_NARROW  = 1;
  localparam int unsigned VAL_EXTREME = 2;

  // One directed row: the request, whether a typed answer follows, the answer.
  typedef struct packed {
    rmt_pkg::in_req_t  req;
    logic              typed;
    rmt_pkg::out_req_t want;
  } dir_row_t;

  // Rows with typed = 1 are readable at a glance; the rest go through the
  // predictor. Covers both field extremes, the sum of the two largest values
  // (needs the extra carry bit), equal values and restarts.
  localparam dir_row_t DIR_ROWS [0:NUM_DIRECTED-1] = '{
    {17'd0,      1'b0, 1'b1, 17'd0,      9'd1, 1'b0},
    {17'd131071, 1'b0, 1'b1, 17'd65535,  9'd2, 1'b0},
    {17'd131071, 1'b0, 1'b1, 17'd131071, 9'd3, 1'b0},
    {17'd0,      1'b0, 1'b1, 17'd65535,  9'd4, 1'b0},
    {17'd5,      1'b1, 1'b1, 17'd5,      9'd1, 1'b0},
    {17'd5,      1'b0, 1'b1, 17'd5,      9'd2, 1'b0},
    {17'd5,      1'b0, 1'b1, 17'd5,      9'd3, 1'b0},
    {17'd131071, 1'b1, 1'b1, 17'd131071, 9'd1, 1'b0},
    {17'd131070, 1'b0, 1'b1, 17'd131070, 9'd2, 1'b0},
    {17'd1,      1'b0, 1'b1, 17'd131070, 9'd3, 1'b0},
    {17'h15555,  1'b1, 1'b1, 17'h15555,  9'd1, 1'b0},
    {17'h0aaaa,  1'b0, 1'b1, 17'd65535,  9'd2, 1'b0},
    {17'd100,    1'b0, 1'b0, 17'd0,      9'd0, 1'b0},
    {17'd7,      1'b0, 1'b0, 17'd0,      9'd0, 1'b0},
    {17'd3,      1'b0, 1'b0, 17'd0,      9'd0, 1'b0},
    {17'd99999,  1'b0, 1'b0, 17'd0,      9'd0, 1'b0},
    {17'd64,     1'b0, 1'b0, 17'd0,      9'd0, 1'b0},
    {17'd12345,  1'b1, 1'b0, 17'd0,      9'd0, 1'b0},
    {17'd2,      1'b0, 1'b0, 17'd0,      9'd0, 1'b0},
    {17'd131071, 1'b0, 1'b0, 17'd0,      9'd0, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  rmt_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rmt_pkg::out_req_t out_req;

  running_median_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  always #10 clk = ~clk;

  // Shadow of the sorted store and its fill level
  logic [rmt_pkg::DATA_W-1:0] sorted_copy [rmt_pkg::CAPACITY];
  int unsigned                copy_count = 0;

  // Medians waiting for the block to produce them, oldest first
  rmt_pkg::out_req_t pending_medians [$];

  // Traffic shaping: idle and stall chances in percent per cycle, and the hold
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned drops_seen = 0;
  int unsigned restarts_sent = 0;
  int unsigned cycle_count = 0;

  rmt_pkg::out_req_t want;

  // Insert one request into the shadow store and return the median that the
  // block must report for it. A restart empties the store first; a full store
  // drops the sample but still reports the median of what it holds.
  function automatic rmt_pkg::out_req_t insert_and_median(input rmt_pkg::in_req_t r);
    rmt_pkg::out_req_t        res;
    int unsigned              pos;
    int unsigned              mid;
    logic [rmt_pkg::DATA_W:0] pair_sum;
    res = '0;
    if (r.restart) copy_count = 0;
    if (copy_count < rmt_pkg::CAPACITY) begin
      pos = copy_count;
      while (pos > 0 && sorted_copy[pos-1] > r.sample) begin
        sorted_copy[pos] = sorted_copy[pos-1];
        pos--;
      end
      sorted_copy[pos] = r.sample;
      copy_count++;
    end else begin
      res.dropped = 1'b1;
    end
    mid = copy_count / 2;
    if (copy_count % 2 == 1) begin
      res.median = sorted_copy[mid];
    end else begin
      pair_sum = {1'b0, sorted_copy[mid-1]} + {1'b0, sorted_copy[mid]};
      res.median = pair_sum[rmt_pkg::DATA_W:1];
    end
    res.stored_count = rmt_pkg::CNT_W'(copy_count);
    return res;
  endfunction

  function automatic logic [rmt_pkg::DATA_W-1:0] pick_value(input int unsigned shape);
    logic [rmt_pkg::DATA_W-1:0] v;
    case (shape)
      VAL_NARROW: v = rmt_pkg::DATA_W'($urandom_range(15));
      VAL_EXTREME: begin
        case ($urandom_range(2))
          0:       v = '0;
          1:       v = rmt_pkg::DATA_W'(SAMPLE_MAX);
          default: v = rmt_pkg::DATA_W'($urandom_range(SAMPLE_MAX));
        endcase
      end
      default: v = rmt_pkg::DATA_W'($urandom_range(SAMPLE_MAX));
    endcase
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance,
  // with in_valid still high so back-to-back requests need no extra edge.
  task automatic push_sample(input rmt_pkg::in_req_t r, input logic typed,
                             input rmt_pkg::out_req_t typed_want);
    rmt_pkg::out_req_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    predicted = insert_and_median(r);
    pending_medians.push_back(typed ? typed_want : predicted);
    requests_sent++;
    if (r.restart) restarts_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stall, or a long hold-off when one is asked for. The
  // hold is counted here so the sender keeps pushing while the block backs up.
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_medians.size() == 0) begin
        $display("%0t: result with nothing pending: median %0d count %0d dropped %0b",
                 $time, out_req.median, out_req.stored_count, out_req.dropped);
        errors++;
      end else begin
        want = pending_medians.pop_front();
        if (out_req.median !== want.median) begin
          $display("%0t: median mismatch: expected %0d, got %0d",
                   $time, want.median, out_req.median);
          errors++;
        end
        if (out_req.stored_count !== want.stored_count) begin
          $display("%0t: stored_count mismatch: expected %0d, got %0d",
                   $time, want.stored_count, out_req.stored_count);
          errors++;
        end
        if (out_req.dropped !== want.dropped) begin
          $display("%0t: dropped mismatch: expected %0b, got %0b",
                   $time, want.dropped, out_req.dropped);
          errors++;
        end
        if (want.dropped) drops_seen++;
        results_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, pending_medians.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rmt_pkg::in_req_t req;
    int unsigned      phase;
    int unsigned      sent_in_phase;
    int unsigned      seq_len;
    int unsigned      shape;
    int unsigned      roll;
    bit               prev_long;
    bit               this_long;
    bit               quiet;
    int unsigned      idle_pct [4];
    int unsigned      stall_pct [4];

    // Phase plan: free-running, sender gaps, receiver stalls, light mix.
    idle_pct  = '{0, 51, 0, 9};
    stall_pct = '{0, 0, 51, 9};
    prev_long = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      push_sample(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    // Random part: runs of samples since a restart. Some runs overfill the
    // store to hit the dropped case, and a run following one of those always
    // restarts, so the restart-with-full-store case is exercised too.
    for (phase = 0; phase < 4; phase++) begin
      sent_in_phase = 0;
      if (phase == 0) hold_asks++;
      while (sent_in_phase < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (phase == 0 && sent_in_phase == 0) seq_len = rmt_pkg::CAPACITY + 44;
        else if (roll < 12) begin
          seq_len = $urandom_range(rmt_pkg::CAPACITY + 44, rmt_pkg::CAPACITY);
        end
        else if (roll < 50) seq_len = $urandom_range(120, 21);
        else seq_len = $urandom_range(20, 1);
        this_long = (seq_len >= rmt_pkg::CAPACITY);
        shape = $urandom_range(VAL_EXTREME, VAL_FULL);
        // Some runs go without random idles or stalls regardless of phase
        quiet = ($urandom_range(3) == 0);
        send_idle_pct  = quiet ? 0 : idle_pct[phase];
        recv_stall_pct = quiet ? 0 : stall_pct[phase];
        for (int i = 0; i < seq_len; i++) begin
          req.sample = pick_value(shape);
          if (i == 0) req.restart = prev_long || ($urandom_range(9) != 0);
          else        req.restart = ($urandom_range(99) == 0);
          push_sample(req, 1'b0, '0);
          sent_in_phase++;
        end
        prev_long = this_long;
      end
    end

    in_valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    while (pending_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d restarts), checked %0d results, %0d %s",
             requests_sent, restarts_sent, results_checked, drops_seen,
             "with full-store drop.");
    $display("Traffic phases: free-running with long receiver hold, sender gaps, ",
             "receiver stalls, mixed.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
